// ----- hw/rtl/rwa_pkg.sv -----
package rwa_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 5;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic update;
		logic div_start;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} stat_t;

endpackage

// ----- hw/rtl/running_window_average_core.sv -----
// Boxcar moving average over the last WINDOW samples, rounded half away from zero.
// Sequence: an accepted request passes the update, start, divider-step and finish states in that order
// before the result is registered; the steps come from the one-bit-per-cycle restoring divider.
// Requests: a new one is taken only back in idle; a stalled result in the output register holds the next.
// Reset (arst_n low, asynchronous): pointer, fill count and sum clear; ring contents undefined.
module running_window_average_core #(
	parameter int WINDOW = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [rwa_pkg::SAMPLE_W-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [rwa_pkg::SAMPLE_W-1:0] average,
	output logic        [rwa_pkg::COUNT_W-1:0]  held_count
);

	rwa_pkg::cmd_t  cmd;
	rwa_pkg::stat_t stat;

	rwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	rwa_datapath #(
		.WINDOW (WINDOW)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sample     (sample),
		.stat       (stat),
		.average    (average),
		.held_count (held_count)
	);

endmodule

// ----- hw/rtl/rwa_ctrl.sv -----
module rwa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_stall,
	input  rwa_pkg::stat_t stat,
	output logic           in_stall,
	output logic           out_valid,
	output rwa_pkg::cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_UPDATE = 5'b00010,
		ST_START  = 5'b00100,
		ST_STEP   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_START;
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_STEP;
			end
			ST_STEP: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold the result until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	a_rise_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result became valid outside the finish state");

	a_accept_starts_update: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_UPDATE))
		else $error("accepted request did not start an update");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.load_out)
		else $error("pending result overwritten");

endmodule

// ----- hw/rtl/rwa_datapath.sv -----
module rwa_datapath #(
	parameter int WINDOW = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rwa_pkg::cmd_t                       cmd,
	input  logic signed [rwa_pkg::SAMPLE_W-1:0] sample,
	output rwa_pkg::stat_t                      stat,
	output logic signed [rwa_pkg::SAMPLE_W-1:0] average,
	output logic        [rwa_pkg::COUNT_W-1:0]  held_count
);

	localparam int SW     = rwa_pkg::SAMPLE_W;
	localparam int CW     = rwa_pkg::COUNT_W;
	localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = SW + $clog2(WINDOW);
	localparam int DVD_W  = SUM_W + 1;
	localparam int DVS_W  = CNT_W + 1;
	localparam int REM_W  = DVS_W + 1;
	localparam int STEP_W = $clog2(DVD_W + 1);
	localparam int AVG_LIM = 2 ** (SW - 1);

	logic        [SW-1:0]     ring_q [WINDOW];
	logic signed [SW-1:0]     sample_q;
	logic signed [SW-1:0]     rd_q;
	logic        [PTR_W-1:0]  wp_q;
	logic        [CNT_W-1:0]  fill_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic        [DVD_W-1:0]  dvd_q;
	logic        [DVS_W-1:0]  dvs_q;
	logic        [REM_W-1:0]  rem_q;
	logic        [STEP_W-1:0] cnt_q;
	logic                     neg_q;
	logic signed [SW-1:0]     avg_q;
	logic        [CW-1:0]     held_q;

	logic                     full;
	logic signed [SUM_W-1:0]  old_term;
	logic signed [SUM_W-1:0]  sum_d;
	logic        [SUM_W-1:0]  mag;
	logic        [DVD_W-1:0]  dvd_init;
	logic        [REM_W-1:0]  shifted;
	logic                     ge;
	logic        [REM_W-1:0]  rem_d;
	logic        [SW-1:0]     quot;
	logic        [CNT_W+CW-1:0] cnt_ext;

	assign full     = (fill_q == CNT_W'(WINDOW));
	assign old_term = full ? SUM_W'(rd_q) : '0;
	assign sum_d    = sum_q - old_term + SUM_W'(sample_q);

	assign mag      = sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
	assign dvd_init = {mag, 1'b0} + DVD_W'(fill_q);

	// one restoring step per cycle, quotient bits shift in behind the dividend
	assign shifted = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
	assign ge      = (shifted >= {1'b0, dvs_q});
	assign rem_d   = ge ? (shifted - {1'b0, dvs_q}) : shifted;

	assign quot    = dvd_q[SW-1:0];
	assign cnt_ext = {{CW{1'b0}}, fill_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
			rd_q     <= ring_q[wp_q];
		end
		if (cmd.update) begin
			ring_q[wp_q] <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.update) begin
				sum_q <= sum_d;
				if (wp_q == PTR_W'(WINDOW - 1)) begin
					wp_q <= '0;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.div_start) begin
				cnt_q <= STEP_W'(DVD_W);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= dvd_init;
			dvs_q <= {fill_q, 1'b0};
			rem_q <= '0;
			neg_q <= sum_q[SUM_W-1];
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= rem_d;
		end
		if (cmd.load_out) begin
			avg_q  <= neg_q ? $signed(-quot) : $signed(quot);
			held_q <= cnt_ext[CW-1:0];
		end
	end

	assign stat.div_last = (cnt_q == STEP_W'(1));
	assign average       = avg_q;
	assign held_count    = held_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW))
		else $error("fill count beyond window");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (dvd_q <= DVD_W'(AVG_LIM)))
		else $error("quotient out of sample range");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (rem_q < {1'b0, dvs_q}))
		else $error("division remainder not below divisor");

endmodule
